// File: sv/mpci_pkg.sv
// Shared types and constants of the multichannel PID unit.
`timescale 1ns / 1ps
`default_nettype none
package mpci_pkg;

	localparam int CHANNELS  = 4;
	localparam int CH_W      = 2;
	localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int GAIN_W    = 16;
	localparam int GAINS_W   = 64;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int LIM_W     = 31;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic signed [31:0] measured;
		logic signed [31:0] measured_rate;
		logic signed [31:0] setpoint;
		logic signed [31:0] rate_setpoint;
		logic signed [31:0] feedforward;
		logic [15:0]        elapsed;
		logic               restart;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0]    out_channel;
		logic signed [31:0] drive;
		logic signed [31:0] error_value;
		logic signed [31:0] integral_value;
		logic               valid_res;
	} out_t;

	// classified sample, as queued between front and back
	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic               ok;
		logic signed [31:0] err;
		logic signed [32:0] rdiff;
		logic signed [31:0] feedforward;
		logic [15:0]        elapsed;
		logic               restart;
	} cmd_t;

	typedef struct packed {
		logic [GAINS_W-1:0] kp;
		logic [GAINS_W-1:0] kd;
		logic [GAINS_W-1:0] ki;
		logic               enable;
		logic [LIM_W-1:0]   limit;
	} cfg_t;

	typedef struct packed {
		logic               take;
		logic               busy;
		logic               wr;
		logic signed [31:0] integ;
	} bk_stat_t;

endpackage
`default_nettype wire

// File: sv/mpci_front.sv
// Front end: error and rate difference, channel check, two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module mpci_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire mpci_pkg::in_t sample,
	output mpci_pkg::cmd_t     head,
	output logic               head_valid,
	input  wire logic          take
);

	mpci_pkg::cmd_t     cmd;
	mpci_pkg::cmd_t     mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;
	logic signed [32:0] diff;
	logic               do_push;
	logic               do_pop;

	assign diff = {sample.measured[31], sample.measured}
		- {sample.setpoint[31], sample.setpoint};

	always_comb begin
		cmd.channel     = sample.channel;
		cmd.ok          = ({1'b0, sample.channel} < (mpci_pkg::CH_W + 1)'(mpci_pkg::CHANNELS));
		// saturate the 33-bit difference to 32 bits
		if (diff[32] != diff[31]) begin
			cmd.err = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			cmd.err = diff[31:0];
		end
		cmd.rdiff       = {sample.measured_rate[31], sample.measured_rate}
			- {sample.rate_setpoint[31], sample.rate_setpoint};
		cmd.feedforward = sample.feedforward;
		cmd.elapsed     = sample.elapsed;
		cmd.restart     = sample.restart;
	end

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = take && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= cmd;
	end

endmodule
`default_nettype wire

// File: sv/mpci_back.sv
// Back end: integral update and drive sum sequencer with two-entry result queue.
`timescale 1ns / 1ps
`default_nettype none
module mpci_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mpci_pkg::cfg_t cfg,
	input  wire logic           clr_all,
	input  wire mpci_pkg::cmd_t head,
	input  wire logic           head_valid,
	output logic                take,
	output logic                empty,
	input  wire logic           pop,
	output mpci_pkg::out_t      result,
	output mpci_pkg::bk_stat_t  stat
);

	typedef enum logic [1:0] {ST_IDLE, ST_INTEG, ST_KD, ST_KI} state_t;

	state_t                            state_q;
	logic signed [31:0]                store_q [mpci_pkg::CHANNELS];
	mpci_pkg::out_t                    rq_q [2];
	logic                              rwp_q;
	logic                              rrp_q;
	logic [1:0]                        rcnt_q;

	logic [mpci_pkg::CH_W-1:0]         ch_q;
	logic                              ok_q;
	logic signed [31:0]                err_q;
	logic signed [32:0]                rdiff_q;
	logic signed [48:0]                pa_q;
	logic signed [49:0]                pb_q;
	logic signed [51:0]                acc_q;
	logic signed [31:0]                integ_q;

	logic                              start;
	logic                              st_wr;
	logic                              res_push;
	logic                              res_pop;
	logic                              run;
	logic [mpci_pkg::CH_W-1:0]         gch;
	logic [mpci_pkg::GAIN_W-1:0]       gain;
	logic signed [32:0]                mb_x;
	logic signed [49:0]                pb_n;
	logic signed [48:0]                pa_n;
	logic signed [31:0]                st_rd;
	logic signed [33:0]                isum;
	logic signed [33:0]                lim34;
	logic signed [33:0]                nlim34;
	logic signed [31:0]                integ_n;
	logic signed [51:0]                acc_sub;
	logic signed [43:0]                shr;
	logic signed [31:0]                drv_sat;
	mpci_pkg::out_t                    res_n;

	assign start    = (state_q == ST_IDLE) && head_valid && (rcnt_q != 2'd2);
	assign take     = start;
	assign run      = ok_q && cfg.enable;
	assign st_wr    = (state_q == ST_INTEG) && run;
	assign res_push = (state_q == ST_KI);
	assign res_pop  = pop && !empty;
	assign empty    = (rcnt_q == 2'd0);
	assign result   = rq_q[rrp_q];

	// shared gain multiplier: kp in IDLE, kd in INTEG, ki in KD
	always_comb begin
		gch  = ch_q;
		mb_x = rdiff_q;
		unique case (state_q)
			ST_IDLE: begin
				gch  = head.channel;
				gain = cfg.kp[gch*mpci_pkg::GAIN_W +: mpci_pkg::GAIN_W];
				mb_x = {head.err[31], head.err};
			end
			ST_INTEG: begin
				gain = cfg.kd[gch*mpci_pkg::GAIN_W +: mpci_pkg::GAIN_W];
				mb_x = rdiff_q;
			end
			ST_KD: begin
				gain = cfg.ki[gch*mpci_pkg::GAIN_W +: mpci_pkg::GAIN_W];
				mb_x = {integ_q[31], integ_q};
			end
			ST_KI: begin
				gain = '0;
			end
		endcase
	end

	assign pb_n = $signed({1'b0, gain}) * mb_x;
	assign pa_n = $signed({1'b0, head.elapsed}) * head.err;

	// integral read-modify-write, floor of (elapsed*err)/2^16 then clamp
	assign st_rd  = ok_q ? store_q[ch_q[mpci_pkg::CH_IDX_W-1:0]] : 32'sd0;
	assign isum   = {{2{st_rd[31]}}, st_rd} + {pa_q[48], pa_q[48:16]};
	assign lim34  = {3'b000, cfg.limit};
	assign nlim34 = -lim34;

	always_comb begin
		if (!run) begin
			integ_n = st_rd;
		end else if (isum > lim34) begin
			integ_n = lim34[31:0];
		end else if (isum < nlim34) begin
			integ_n = nlim34[31:0];
		end else begin
			integ_n = isum[31:0];
		end
	end

	assign acc_sub = acc_q - {{2{pb_q[49]}}, pb_q};
	assign shr     = acc_sub[51:8];

	always_comb begin
		if (!((&shr[43:31]) || !(|shr[43:31]))) begin
			drv_sat = shr[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			drv_sat = shr[31:0];
		end
		res_n.out_channel    = ch_q;
		res_n.drive          = run ? drv_sat : 32'sd0;
		res_n.error_value    = run ? err_q : 32'sd0;
		res_n.integral_value = integ_q;
		res_n.valid_res      = run;
	end

	assign stat.take  = start;
	assign stat.busy  = (state_q != ST_IDLE);
	assign stat.wr    = st_wr;
	assign stat.integ = integ_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < mpci_pkg::CHANNELS; i++) store_q[i] <= 32'sd0;
			rwp_q   <= 1'b0;
			rrp_q   <= 1'b0;
			rcnt_q  <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_KD;
				ST_KD:    state_q <= ST_KI;
				ST_KI:    state_q <= ST_IDLE;
			endcase
			priority if (clr_all || (start && head.restart)) begin
				for (int i = 0; i < mpci_pkg::CHANNELS; i++) store_q[i] <= 32'sd0;
			end else if (st_wr) begin
				store_q[ch_q[mpci_pkg::CH_IDX_W-1:0]] <= integ_n;
			end else begin
				// store holds
			end
			if (res_push) rwp_q <= ~rwp_q;
			if (res_pop) rrp_q <= ~rrp_q;
			rcnt_q <= rcnt_q + 2'(res_push) - 2'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ch_q    <= head.channel;
			ok_q    <= head.ok;
			err_q   <= head.err;
			rdiff_q <= head.rdiff;
			pa_q    <= pa_n;
			acc_q   <= {{12{head.feedforward[31]}}, head.feedforward, 8'h00};
		end else if (state_q == ST_INTEG || state_q == ST_KD) begin
			acc_q <= acc_sub;
		end
		if (start || state_q == ST_INTEG || state_q == ST_KD) pb_q <= pb_n;
		if (state_q == ST_INTEG) integ_q <= integ_n;
		if (res_push) rq_q[rwp_q] <= res_n;
	end

endmodule
`default_nettype wire

// File: sv/multichannel_pid_clamped_integral_unit.sv
// Top level of the multichannel PID unit with clamped integral.
//
//   channel   direction  handshake         payload
//   sample    in         push / full       mpci_pkg::in_t
//   result    out        pop / empty       mpci_pkg::out_t
//   config    in         cfg_we            cfg_index, cfg_data (64 bit)
//
// A sample transaction waits in the two-entry command queue, then passes through the
// back-end sequencer states IDLE, INTEG, KD and KI; a new one is taken only back in IDLE,
// since the single gain multiplier is shared by the kp, kd and ki terms in turn.
// Reset: integrals zero, enable 0, gains 0, integral limit 2^31-1.
// full rises with two commands queued; the sequencer waits while the result queue is full.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_pid_clamped_integral_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire mpci_pkg::in_t                     sample,
	output logic                                   empty,
	input  wire logic                              pop,
	output mpci_pkg::out_t                         result,
	input  wire logic                              cfg_we,
	input  wire logic [mpci_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mpci_pkg::CFG_W-1:0]        cfg_data
);

	logic                              enable_q;
	logic [mpci_pkg::GAINS_W-1:0]      kp_q;
	logic [mpci_pkg::GAINS_W-1:0]      kd_q;
	logic [mpci_pkg::GAINS_W-1:0]      ki_q;
	logic [mpci_pkg::LIM_W-1:0]        lim_q;
	logic                              clr_all;
	mpci_pkg::cfg_t                    cfg;
	mpci_pkg::cmd_t                    head;
	logic                              head_valid;
	logic                              take;
	mpci_pkg::bk_stat_t                stat;

	// enabling clears every integral
	assign clr_all = cfg_we && (cfg_index == mpci_pkg::REG_ENABLE) && cfg_data[0] && !enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			kp_q     <= '0;
			kd_q     <= '0;
			ki_q     <= '0;
			lim_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpci_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				mpci_pkg::REG_KP:     kp_q     <= cfg_data[mpci_pkg::GAINS_W-1:0];
				mpci_pkg::REG_KD:     kd_q     <= cfg_data[mpci_pkg::GAINS_W-1:0];
				mpci_pkg::REG_KI:     ki_q     <= cfg_data[mpci_pkg::GAINS_W-1:0];
				mpci_pkg::REG_LIMIT:  lim_q    <= cfg_data[mpci_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.kp     = kp_q;
		cfg.kd     = kd_q;
		cfg.ki     = ki_q;
		cfg.enable = enable_q;
		cfg.limit  = lim_q;
	end

	mpci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.head       (head),
		.head_valid (head_valid),
		.take       (take)
	);

	mpci_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clr_all    (clr_all),
		.head       (head),
		.head_valid (head_valid),
		.take       (take),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.stat       (stat)
	);

	a_take_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |-> head_valid)
		else $error("back end took a transaction from an empty command queue");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |=> stat.busy)
		else $error("sequencer did not start after taking a transaction");

	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.wr |-> (stat.integ <= $signed({1'b0, lim_q}))
			&& (stat.integ >= -$signed({1'b0, lim_q})))
		else $error("integral written outside the clamp limit");

endmodule
`default_nettype wire

// File: sim/multichannel_pid_clamped_integral_unit_tb.sv
// Self-checking testbench for the multichannel PID unit with clamped integral.
`timescale 1ns / 1ps
module multichannel_pid_clamped_integral_unit_tb;

	localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S_MIN = 32'h8000_0000;
	localparam int DRAIN_GAP = 12;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 235;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	mpci_pkg::in_t sample;
	logic empty;
	logic pop;
	mpci_pkg::out_t result;
	logic cfg_we;
	logic [mpci_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mpci_pkg::CFG_W-1:0] cfg_data;

	multichannel_pid_clamped_integral_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state and register copy
	logic signed [31:0] integ_mem [mpci_pkg::CHANNELS];
	logic en_q;
	logic [mpci_pkg::GAINS_W-1:0] kp_q, kd_q, ki_q;
	logic [mpci_pkg::LIM_W-1:0] lim_q;

	mpci_pkg::out_t drive_expect_q [$];
	int error_count;
	int n_sent;
	int n_checked;
	int n_valid;
	int push_gap_pct;
	int pop_stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic longint clip_s32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint channel_gain(logic [mpci_pkg::GAINS_W-1:0] g, int ch);
		return longint'(g[mpci_pkg::GAIN_W*ch +: mpci_pkg::GAIN_W]);
	endfunction

	function automatic void clear_integrals();
		foreach (integ_mem[i])
			integ_mem[i] = '0;
	endfunction

	function automatic void apply_reg_write(logic [mpci_pkg::CFG_IDX_W-1:0] idx,
			logic [mpci_pkg::CFG_W-1:0] val);
		case (idx)
			mpci_pkg::REG_ENABLE: begin
				// rising enable restarts every channel
				if (val[0] && !en_q)
					clear_integrals();
				en_q = val[0];
			end
			mpci_pkg::REG_KP: kp_q = val;
			mpci_pkg::REG_KD: kd_q = val;
			mpci_pkg::REG_KI: ki_q = val;
			mpci_pkg::REG_LIMIT: lim_q = val[mpci_pkg::LIM_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic mpci_pkg::out_t pid_predict(mpci_pkg::in_t s);
		mpci_pkg::out_t r;
		longint err, integ, rdiff, sum, lim;
		int ch;
		r = '0;
		ch = int'(s.channel);
		if (s.restart)
			clear_integrals();
		r.out_channel = s.channel;
		if (ch < mpci_pkg::CHANNELS) begin
			integ = longint'(integ_mem[ch]);
			if (en_q) begin
				err = clip_s32(longint'($signed(s.measured)) - longint'($signed(s.setpoint)));
				integ = integ + ((longint'(s.elapsed) * err) >>> 16);
				lim = longint'(lim_q);
				if (integ > lim)
					integ = lim;
				else if (integ < -lim)
					integ = -lim;
				integ_mem[ch] = integ[31:0];
				rdiff = longint'($signed(s.measured_rate)) - longint'($signed(s.rate_setpoint));
				sum = longint'($signed(s.feedforward)) * 256
					- channel_gain(kp_q, ch) * err
					- channel_gain(kd_q, ch) * rdiff
					- channel_gain(ki_q, ch) * integ;
				r.drive = 32'(clip_s32(sum >>> 8));
				r.error_value = err[31:0];
				r.valid_res = 1'b1;
			end
			r.integral_value = integ[31:0];
		end
		return r;
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, what, want, got);
			error_count++;
		end
	endfunction

	// register writes, accepted samples and accepted results, all seen at the clock edge
	always @(posedge clk) begin : monitor
		mpci_pkg::out_t want;
		if (arst_n) begin
			if (cfg_we)
				apply_reg_write(cfg_index, cfg_data);
			if (push && !full) begin
				drive_expect_q.push_back(pid_predict(sample));
				n_sent++;
			end
			if (pop && !empty) begin
				if (drive_expect_q.size() == 0) begin
					$display("%0t: result transaction with nothing expected, actual %p",
						$time, result);
					error_count++;
				end else begin
					want = drive_expect_q.pop_front();
					note_mismatch("out_channel", 32'(want.out_channel), 32'(result.out_channel));
					note_mismatch("drive", want.drive, result.drive);
					note_mismatch("error_value", want.error_value, result.error_value);
					note_mismatch("integral_value", want.integral_value, result.integral_value);
					note_mismatch("valid_res", 32'(want.valid_res), 32'(result.valid_res));
					n_checked++;
					if (want.valid_res)
						n_valid++;
				end
			end
		end
	end

	always @(posedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	task automatic send_sample(input mpci_pkg::in_t s);
		while ($urandom_range(99) < push_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (full);
	endtask

	// wait until every expected result is back and the back end has settled
	task automatic drain_results();
		push <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mpci_pkg::CFG_IDX_W-1:0] idx,
			input logic [mpci_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic mpci_pkg::in_t pid_sample(logic [1:0] ch, logic [31:0] m,
			logic [31:0] mr, logic [31:0] sp, logic [31:0] rsp, logic [31:0] ff,
			logic [15:0] el, logic rs);
		mpci_pkg::in_t s;
		s.channel = ch;
		s.measured = m;
		s.measured_rate = mr;
		s.setpoint = sp;
		s.rate_setpoint = rsp;
		s.feedforward = ff;
		s.elapsed = el;
		s.restart = rs;
		return s;
	endfunction

	function automatic logic [31:0] random_q1616();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return S_MAX;
					1: return S_MIN;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3, 4: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic mpci_pkg::in_t random_sample();
		mpci_pkg::in_t s;
		s.channel = 2'($urandom);
		s.measured = random_q1616();
		// half the time track the setpoint closely so integrals wander instead of pinning
		if ($urandom_range(1))
			s.setpoint = s.measured + $urandom_range(32'h0002_0000) - 32'h0001_0000;
		else
			s.setpoint = random_q1616();
		s.measured_rate = random_q1616();
		s.rate_setpoint = random_q1616();
		s.feedforward = random_q1616();
		case ($urandom_range(9))
			0: s.elapsed = 16'h0;
			1: s.elapsed = 16'hFFFF;
			2, 3, 4: s.elapsed = 16'($urandom);
			default: s.elapsed = 16'($urandom_range(16'h0800));
		endcase
		s.restart = ($urandom_range(99) < 3);
		return s;
	endfunction

	function automatic logic [mpci_pkg::GAINS_W-1:0] random_gains();
		logic [mpci_pkg::GAINS_W-1:0] g;
		case ($urandom_range(5))
			0: g = '0;
			1: g = '1;
			default: begin
				for (int c = 0; c < 4; c++)
					g[mpci_pkg::GAIN_W*c +: mpci_pkg::GAIN_W] = $urandom_range(1)
						? 16'($urandom_range(16'h0300)) : 16'($urandom);
			end
		endcase
		return g;
	endfunction

	function automatic logic [mpci_pkg::CFG_W-1:0] random_limit();
		logic [mpci_pkg::CFG_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(4))
			0: v[mpci_pkg::LIM_W-1:0] = '0;
			1: v[mpci_pkg::LIM_W-1:0] = '1;
			2: v[mpci_pkg::LIM_W-1:0] = 31'($urandom_range(32'h0004_0000));
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_disabled_after_reset();
		send_sample(pid_sample(2'd0, S_MAX, 32'h1234, 32'h0, 32'h0, S_MAX, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd3, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN, 16'h0, 1'b1));
		send_sample(pid_sample(2'd1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h100, 1'b0));
	endtask

	task automatic test_extremes();
		drain_results();
		write_reg(mpci_pkg::REG_KP, {16'hFFFF, 16'h0280, 16'h0100, 16'h0000});
		write_reg(mpci_pkg::REG_KD, {16'hFFFF, 16'h0001, 16'h8000, 16'h0000});
		write_reg(mpci_pkg::REG_KI, {16'hFFFF, 16'h0040, 16'h0100, 16'h0000});
		write_reg(mpci_pkg::REG_LIMIT, 64'h0000_0000_7FFF_FFFF);
		write_reg(mpci_pkg::REG_ENABLE, 64'h1);
		// error saturation both ways
		send_sample(pid_sample(2'd0, S_MAX, 32'h0, S_MIN, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd1, S_MIN, 32'h0, S_MAX, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		// rate difference needs the full 33 bits
		send_sample(pid_sample(2'd2, 32'h0, S_MAX, 32'h0, S_MIN, S_MAX, 16'h0010, 1'b0));
		send_sample(pid_sample(2'd3, 32'h0, S_MIN, 32'h0, S_MAX, S_MIN, 16'h0010, 1'b0));
		send_sample(pid_sample(2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0));
		send_sample(pid_sample(2'd1, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
			16'h8000, 1'b1));
		// floor of a tiny negative increment
		send_sample(pid_sample(2'd2, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 16'h1, 1'b0));
	endtask

	task automatic test_integral_clamp();
		drain_results();
		write_reg(mpci_pkg::REG_LIMIT, 64'hFFFF_FFFF_8000_0000);
		send_sample(pid_sample(2'd0, S_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd1, S_MIN, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		drain_results();
		write_reg(mpci_pkg::REG_LIMIT, 64'h0000_0000_0001_0000);
		send_sample(pid_sample(2'd2, S_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd2, S_MIN, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd2, 32'h0000_4000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h4000, 1'b0));
		send_sample(pid_sample(2'd3, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0100, 1'b1));
		drain_results();
		write_reg(mpci_pkg::REG_LIMIT, 64'h0000_0000_7FFF_FFFF);
		send_sample(pid_sample(2'd0, S_MAX, 32'h0, S_MIN, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd0, S_MAX, 32'h0, S_MIN, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd0, S_MIN, 32'h0, S_MAX, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd0, S_MIN, 32'h0, S_MAX, 32'h0, 32'h0, 16'hFFFF, 1'b0));
	endtask

	task automatic test_enable_toggle();
		drain_results();
		write_reg(mpci_pkg::REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
		// disabled: stored integral shows through, nothing updates
		send_sample(pid_sample(2'd0, S_MAX, 32'h0, 32'h0, 32'h0, S_MAX, 16'hFFFF, 1'b0));
		send_sample(pid_sample(2'd2, S_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0));
		drain_results();
		write_reg(mpci_pkg::REG_ENABLE, 64'h1);
		send_sample(pid_sample(2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0));
		send_sample(pid_sample(2'd1, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0));
		drain_results();
		// enable already set: integrals survive the write
		write_reg(mpci_pkg::REG_ENABLE, 64'h3);
		send_sample(pid_sample(2'd1, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0));
	endtask

	task automatic test_random_phases();
		logic [mpci_pkg::CFG_W-1:0] en_word;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			push_gap_pct = (ph == 5) ? 0 : 14;
			pop_stall_pct = (ph == 5) ? 0 : 14;
			write_reg(mpci_pkg::REG_KP, random_gains());
			write_reg(mpci_pkg::REG_KD, random_gains());
			write_reg(mpci_pkg::REG_KI, random_gains());
			write_reg(mpci_pkg::REG_LIMIT, random_limit());
			en_word = {$urandom, $urandom};
			en_word[0] = (ph != 3);
			write_reg(mpci_pkg::REG_ENABLE, en_word);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 2 && i == PHASE_ITEMS / 2)
					drain_results();
				send_sample(random_sample());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		sample <= '0;
		pop <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mpci_pkg::REG_ENABLE;
		cfg_data <= '0;
		error_count = 0;
		n_sent = 0;
		n_checked = 0;
		n_valid = 0;
		push_gap_pct = 14;
		pop_stall_pct = 14;
		clear_integrals();
		en_q = 1'b0;
		kp_q = '0;
		kd_q = '0;
		ki_q = '0;
		lim_q = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_after_reset();
		test_extremes();
		test_integral_clamp();
		test_enable_toggle();
		test_random_phases();
		drain_results();

		$display("Sent %0d samples (directed, then %0d random phases of varied gains, limits",
			n_sent, RANDOM_PHASES);
		$display("and enable); checked %0d results, %0d of them with a valid drive.",
			n_checked, n_valid);
		if (error_count == 0 && drive_expect_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
